>>> hdl/swarq_pkg.sv
package swarq_pkg;

    typedef enum logic [2:0] {
        MODE_CLOSED,
        MODE_SYN,
        MODE_OPEN,
        MODE_PSH,
        MODE_FIN,
        MODE_FIN2
    } t_mode;

    localparam logic [2:0] KIND_CONNECT = 3'd0;
    localparam logic [2:0] KIND_SEND    = 3'd1;
    localparam logic [2:0] KIND_DISC    = 3'd2;
    localparam logic [2:0] KIND_RXWORD  = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    localparam logic [1:0] PKT_SYN = 2'd0;
    localparam logic [1:0] PKT_ACK = 2'd1;
    localparam logic [1:0] PKT_FIN = 2'd2;
    localparam logic [1:0] PKT_PSH = 2'd3;

    localparam logic [7:0] RX_SYNACK = 8'd2;
    localparam logic [7:0] RX_ACK    = 8'd4;
    localparam logic [7:0] RX_FINACK = 8'd8;

    localparam logic [2:0] ST_CONNECTED = 3'd0;
    localparam logic [2:0] ST_FILE_SENT = 3'd1;
    localparam logic [2:0] ST_CLOSED    = 3'd2;
    localparam logic [2:0] ST_CLOSE_ERR = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic       ACT_PKT    = 1'b0;
    localparam logic       ACT_STATUS = 1'b1;

    localparam logic [12:0] SEG_MAX       = 13'd8000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] SUM_GOOD      = 16'hffff;
    localparam logic [15:0] TIMER_MAX     = 16'hffff;
    localparam logic [2:0]  HDR_INDEX     = 3'd4;
    localparam logic [2:0]  CNT_SAT       = 3'd5;

    typedef struct packed {
        logic        action;
        logic [1:0]  pkt_type;
        logic [7:0]  pkt_seq;
        logic [12:0] seg_len;
        logic [2:0]  status;
        logic        last;
    } t_result;

    function automatic t_result mk_pkt(logic [1:0] ptype, logic [7:0] seq,
                                       logic [12:0] len);
        t_result r;
        r.action   = ACT_PKT;
        r.pkt_type = ptype;
        r.pkt_seq  = seq;
        r.seg_len  = len;
        r.status   = 3'd0;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic t_result mk_status(logic [2:0] code);
        t_result r;
        r.action   = ACT_STATUS;
        r.pkt_type = 2'd0;
        r.pkt_seq  = 8'd0;
        r.seg_len  = 13'd0;
        r.status   = code;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/stop_and_wait_arq_sender.sv
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_kind, i_rx_word, i_last_word, i_file_length
// result    out        o_valid / i_ready   o_action, o_pkt_type, o_pkt_seq, o_seg_len,
//                                          o_status, o_last
// config    in         i_cfg_wr_en         i_cfg_wr_data (timeout in ticks)
//
// One item per cycle while input is taken: state updates in the cycle of the transfer, its
// results (up to two) are registered in a four-entry result queue.
// Input is taken while the queue has room for two results, so a stalled
// output blocks input once three results are waiting.
// Synchronous active-low reset: mode closed, counters clear, timeout 100.
module stop_and_wait_arq_sender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_rx_word,
    input  logic        i_last_word,
    input  logic [26:0] i_file_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_action,
    output logic [1:0]  o_pkt_type,
    output logic [7:0]  o_pkt_seq,
    output logic [12:0] o_seg_len,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import swarq_pkg::*;

    t_mode       r_mode,    n_mode;
    logic [7:0]  r_seq,     n_seq;
    logic [15:0] r_timer,   n_timer;
    logic [15:0] r_sum,     n_sum;
    logic [2:0]  r_cnt,     n_cnt;
    logic [15:0] r_hdr,     n_hdr;
    logic [26:0] r_bytes,   n_bytes;
    logic [12:0] r_pending, n_pending;
    logic [15:0] r_timeout;

    t_result     r_buf [4];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_count, n_count;

    logic        acc, pop;
    logic [16:0] sum_wide;
    logic [15:0] sum_acc;
    logic [2:0]  cnt_acc;
    logic [15:0] hdr_acc;
    logic        has_hdr, sum_ok, match;
    logic        syn_ok, ack_ok, fin2_ok;
    logic [7:0]  seq_p1;
    logic [26:0] seg_src, bytes_rem;
    logic [12:0] seg_len;
    logic        waiting;
    logic [15:0] timer_inc;
    logic        timeout_hit;
    t_result     resend_pkt;
    t_result     res0, res1;
    logic [1:0]  push_n;

    assign acc = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_ready = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);

    // received word datapath
    assign sum_wide = {1'b0, r_sum} + {1'b0, i_rx_word};
    assign sum_acc  = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
    assign cnt_acc  = (r_cnt < CNT_SAT) ? (r_cnt + 3'd1) : r_cnt;
    assign hdr_acc  = (r_cnt == HDR_INDEX) ? i_rx_word : r_hdr;
    assign has_hdr  = (cnt_acc >= CNT_SAT);
    assign sum_ok   = (sum_acc == SUM_GOOD);
    assign match    = has_hdr && sum_ok && (hdr_acc[15:8] == r_seq);
    assign syn_ok   = match && (hdr_acc[7:0] == RX_SYNACK);
    assign ack_ok   = match && (hdr_acc[7:0] == RX_ACK);
    assign fin2_ok  = has_hdr && (hdr_acc[7:0] == RX_FINACK);
    assign seq_p1   = r_seq + 8'd1;

    // segmenter
    assign seg_src   = (i_kind == KIND_SEND) ? i_file_length : r_bytes;
    assign seg_len   = (seg_src >= {14'd0, SEG_MAX}) ? SEG_MAX : seg_src[12:0];
    assign bytes_rem = seg_src - {14'd0, seg_len};

    assign waiting     = (r_mode == MODE_SYN) || (r_mode == MODE_PSH) ||
                         (r_mode == MODE_FIN);
    assign timer_inc   = (r_timer != TIMER_MAX) ? (r_timer + 16'd1) : r_timer;
    assign timeout_hit = (timer_inc >= r_timeout);

    always_comb begin
        unique case (r_mode)
            MODE_SYN: resend_pkt = mk_pkt(PKT_SYN, r_seq, 13'd0);
            MODE_PSH: resend_pkt = mk_pkt(PKT_PSH, r_seq, r_pending);
            default:  resend_pkt = mk_pkt(PKT_FIN, r_seq, 13'd0);
        endcase
    end

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_seq     = r_seq;
        n_timer   = r_timer;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_hdr     = r_hdr;
        n_bytes   = r_bytes;
        n_pending = r_pending;
        if (acc) begin
            unique case (i_kind)
                KIND_CONNECT: begin
                    if (r_mode == MODE_CLOSED) begin
                        n_mode  = MODE_SYN;
                        n_timer = 16'd0;
                    end
                end
                KIND_SEND: begin
                    if (r_mode == MODE_OPEN) begin
                        n_bytes   = bytes_rem;
                        n_pending = seg_len;
                        n_timer   = 16'd0;
                        n_mode    = MODE_PSH;
                    end
                end
                KIND_DISC: begin
                    if (r_mode == MODE_OPEN) begin
                        n_mode  = MODE_FIN;
                        n_timer = 16'd0;
                    end
                end
                KIND_RXWORD: begin
                    n_sum = sum_acc;
                    n_cnt = cnt_acc;
                    n_hdr = hdr_acc;
                    if (i_last_word) begin
                        n_sum = 16'd0;
                        n_cnt = 3'd0;
                        n_hdr = 16'd0;
                        unique case (r_mode)
                            MODE_FIN2: n_mode = MODE_CLOSED;
                            MODE_SYN: begin
                                if (syn_ok) begin
                                    n_seq  = r_seq + 8'd2;
                                    n_mode = MODE_OPEN;
                                end else begin
                                    n_timer = 16'd0;
                                end
                            end
                            MODE_PSH: begin
                                if (ack_ok) begin
                                    n_seq = seq_p1;
                                    if (r_pending < SEG_MAX) begin
                                        n_mode    = MODE_OPEN;
                                        n_pending = 13'd0;
                                    end else begin
                                        n_bytes   = bytes_rem;
                                        n_pending = seg_len;
                                        n_timer   = 16'd0;
                                    end
                                end else begin
                                    n_timer = 16'd0;
                                end
                            end
                            MODE_FIN: begin
                                if (ack_ok) begin
                                    n_mode = MODE_FIN2;
                                end else begin
                                    n_timer = 16'd0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                KIND_TICK: begin
                    if (waiting) begin
                        n_timer = timeout_hit ? 16'd0 : timer_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // results of the accepted item
    always_comb begin
        res0   = mk_status(ST_REJECTED);
        res1   = mk_status(ST_REJECTED);
        push_n = 2'd0;
        if (acc) begin
            unique case (i_kind)
                KIND_CONNECT: begin
                    push_n = 2'd1;
                    if (r_mode == MODE_CLOSED) begin
                        res0 = mk_pkt(PKT_SYN, r_seq, 13'd0);
                    end
                end
                KIND_SEND: begin
                    push_n = 2'd1;
                    if (r_mode == MODE_OPEN) begin
                        res0 = mk_pkt(PKT_PSH, r_seq, seg_len);
                    end
                end
                KIND_DISC: begin
                    push_n = 2'd1;
                    if (r_mode == MODE_OPEN) begin
                        res0 = mk_pkt(PKT_FIN, r_seq, 13'd0);
                    end
                end
                KIND_RXWORD: begin
                    if (i_last_word) begin
                        unique case (r_mode)
                            MODE_FIN2: begin
                                if (fin2_ok) begin
                                    res0   = mk_pkt(PKT_ACK, hdr_acc[15:8], 13'd0);
                                    res1   = mk_status(ST_CLOSED);
                                    push_n = 2'd2;
                                end else begin
                                    res0   = mk_status(ST_CLOSE_ERR);
                                    push_n = 2'd1;
                                end
                            end
                            MODE_SYN: begin
                                if (syn_ok) begin
                                    res0   = mk_pkt(PKT_ACK, seq_p1, 13'd0);
                                    res1   = mk_status(ST_CONNECTED);
                                    push_n = 2'd2;
                                end else begin
                                    res0   = resend_pkt;
                                    push_n = 2'd1;
                                end
                            end
                            MODE_PSH: begin
                                push_n = 2'd1;
                                if (!ack_ok) begin
                                    res0 = resend_pkt;
                                end else if (r_pending < SEG_MAX) begin
                                    res0 = mk_status(ST_FILE_SENT);
                                end else begin
                                    res0 = mk_pkt(PKT_PSH, seq_p1, seg_len);
                                end
                            end
                            MODE_FIN: begin
                                if (!ack_ok) begin
                                    res0   = resend_pkt;
                                    push_n = 2'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                KIND_TICK: begin
                    if (waiting && timeout_hit) begin
                        res0   = resend_pkt;
                        push_n = 2'd1;
                    end
                end
                default: ;
            endcase
        end
        res0.last = (push_n == 2'd1);
        res1.last = (push_n == 2'd2);
    end

    assign n_count = r_count + {1'b0, push_n} - {2'd0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CLOSED;
            r_seq     <= 8'd0;
            r_timer   <= 16'd0;
            r_sum     <= 16'd0;
            r_cnt     <= 3'd0;
            r_hdr     <= 16'd0;
            r_bytes   <= 27'd0;
            r_pending <= 13'd0;
            r_timeout <= TIMEOUT_RESET;
            r_wr      <= 2'd0;
            r_rd      <= 2'd0;
            r_count   <= 3'd0;
        end else begin
            r_mode    <= n_mode;
            r_seq     <= n_seq;
            r_timer   <= n_timer;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_hdr     <= n_hdr;
            r_bytes   <= n_bytes;
            r_pending <= n_pending;
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            r_wr      <= r_wr + push_n;
            r_rd      <= r_rd + {1'b0, pop};
            r_count   <= n_count;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_buf[r_wr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_buf[r_wr + 2'd1] <= res1;
        end
    end

    assign o_action   = r_buf[r_rd].action;
    assign o_pkt_type = r_buf[r_rd].pkt_type;
    assign o_pkt_seq  = r_buf[r_rd].pkt_seq;
    assign o_seg_len  = r_buf[r_rd].seg_len;
    assign o_status   = r_buf[r_rd].status;
    assign o_last     = r_buf[r_rd].last;

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> ({1'b0, r_count} + {2'd0, push_n} <= 4'd4))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result count out of range");

    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_seq))
        else $error("sequence changed without a transfer");

    a_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind == KIND_CONNECT && r_mode == MODE_CLOSED) |=> r_mode == MODE_SYN)
        else $error("connect did not start handshake");

    a_fin2_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FIN2 && $past(r_mode) != MODE_FIN2) |-> $past(r_mode) == MODE_FIN)
        else $error("peer close wait entered from wrong mode");

endmodule

>>> tb/tb_stop_and_wait_arq_sender.sv
module tb_stop_and_wait_arq_sender;
    timeunit 1ns;
    timeprecision 1ps;

    import swarq_pkg::*;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] word;
        logic        lastw;
        logic [26:0] flen;
        bit          hold;
    } t_arq_item;

    typedef struct {
        t_mode       mode;
        logic [7:0]  seq;
        logic [15:0] timer;
        logic [15:0] sum;
        logic [2:0]  cnt;
        logic [15:0] hdr;
        logic [26:0] left;
        logic [12:0] pend;
        logic [15:0] tmo;
    } t_arq_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_kind = '0;
    logic [15:0] i_rx_word = '0;
    logic        i_last_word = 1'b0;
    logic [26:0] i_file_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_action;
    logic [1:0]  o_pkt_type;
    logic [7:0]  o_pkt_seq;
    logic [12:0] o_seg_len;
    logic [2:0]  o_status;
    logic        o_last;

    t_arq_item  pending_items[$];
    t_result    due_results[$];
    t_arq_state arq_model;
    t_arq_state arq_plan;
    t_arq_item  in_flight;
    t_result    step_res [2];
    int         step_n;
    t_result    got;
    t_result    want;
    int         mismatches = 0;
    int         queued = 0;
    bit         steady = 1'b0;

    stop_and_wait_arq_sender dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_rx_word     (i_rx_word),
        .i_last_word   (i_last_word),
        .i_file_length (i_file_length),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_action      (o_action),
        .o_pkt_type    (o_pkt_type),
        .o_pkt_seq     (o_pkt_seq),
        .o_seg_len     (o_seg_len),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result make_result(logic act, logic [1:0] ptype, logic [7:0] seq,
                                            logic [12:0] len, logic [2:0] code);
        t_result r;
        r.action   = act;
        r.pkt_type = ptype;
        r.pkt_seq  = seq;
        r.seg_len  = len;
        r.status   = code;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic t_result next_segment(inout t_arq_state s);
        logic [12:0] seg;
        seg = (s.left >= SEG_MAX) ? SEG_MAX : s.left[12:0];
        s.left  = s.left - seg;
        s.pend  = seg;
        s.timer = '0;
        s.mode  = MODE_PSH;
        return make_result(ACT_PKT, PKT_PSH, s.seq, seg, '0);
    endfunction

    function automatic t_result resend_pending(inout t_arq_state s);
        s.timer = '0;
        case (s.mode)
            MODE_SYN: return make_result(ACT_PKT, PKT_SYN, s.seq, '0, '0);
            MODE_PSH: return make_result(ACT_PKT, PKT_PSH, s.seq, s.pend, '0);
            default:  return make_result(ACT_PKT, PKT_FIN, s.seq, '0, '0);
        endcase
    endfunction

    // Advances the sender state by one item and returns how many results it gives.
    function automatic int arq_response(inout t_arq_state s, input t_arq_item c,
                                        output t_result res [2]);
        int          n;
        logic [16:0] acc;
        logic [7:0]  rtype;
        logic [7:0]  rseq;
        logic        has_hdr;
        logic        match;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        case (c.kind)
            KIND_CONNECT: begin
                if (s.mode == MODE_CLOSED) begin
                    s.mode  = MODE_SYN;
                    s.timer = '0;
                    res[0] = make_result(ACT_PKT, PKT_SYN, s.seq, '0, '0);
                end else begin
                    res[0] = make_result(ACT_STATUS, '0, '0, '0, ST_REJECTED);
                end
                n = 1;
            end
            KIND_SEND: begin
                if (s.mode == MODE_OPEN) begin
                    s.left = c.flen;
                    res[0] = next_segment(s);
                end else begin
                    res[0] = make_result(ACT_STATUS, '0, '0, '0, ST_REJECTED);
                end
                n = 1;
            end
            KIND_DISC: begin
                if (s.mode == MODE_OPEN) begin
                    s.mode  = MODE_FIN;
                    s.timer = '0;
                    res[0] = make_result(ACT_PKT, PKT_FIN, s.seq, '0, '0);
                end else begin
                    res[0] = make_result(ACT_STATUS, '0, '0, '0, ST_REJECTED);
                end
                n = 1;
            end
            KIND_RXWORD: begin
                acc = {1'b0, s.sum} + {1'b0, c.word};
                if (acc[16]) begin
                    acc = {1'b0, acc[15:0]} + 17'd1;
                end
                s.sum = acc[15:0];
                if (s.cnt == HDR_INDEX) begin
                    s.hdr = c.word;
                end
                if (s.cnt < CNT_SAT) begin
                    s.cnt = s.cnt + 3'd1;
                end
                if (c.lastw) begin
                    rtype   = s.hdr[7:0];
                    rseq    = s.hdr[15:8];
                    has_hdr = (s.cnt >= CNT_SAT);
                    match   = has_hdr && (s.sum == SUM_GOOD) && (rseq == s.seq);
                    case (s.mode)
                        MODE_FIN2: begin
                            s.mode = MODE_CLOSED;
                            if (has_hdr && rtype == RX_FINACK) begin
                                res[0] = make_result(ACT_PKT, PKT_ACK, rseq, '0, '0);
                                res[1] = make_result(ACT_STATUS, '0, '0, '0, ST_CLOSED);
                                n = 2;
                            end else begin
                                res[0] = make_result(ACT_STATUS, '0, '0, '0, ST_CLOSE_ERR);
                                n = 1;
                            end
                        end
                        MODE_SYN: begin
                            if (match && rtype == RX_SYNACK) begin
                                s.seq = s.seq + 8'd1;
                                res[0] = make_result(ACT_PKT, PKT_ACK, s.seq, '0, '0);
                                s.seq  = s.seq + 8'd1;
                                s.mode = MODE_OPEN;
                                res[1] = make_result(ACT_STATUS, '0, '0, '0, ST_CONNECTED);
                                n = 2;
                            end else begin
                                res[0] = resend_pending(s);
                                n = 1;
                            end
                        end
                        MODE_PSH: begin
                            if (match && rtype == RX_ACK) begin
                                s.seq = s.seq + 8'd1;
                                if (s.pend < SEG_MAX) begin
                                    s.mode = MODE_OPEN;
                                    s.pend = '0;
                                    res[0] = make_result(ACT_STATUS, '0, '0, '0, ST_FILE_SENT);
                                end else begin
                                    res[0] = next_segment(s);
                                end
                            end else begin
                                res[0] = resend_pending(s);
                            end
                            n = 1;
                        end
                        MODE_FIN: begin
                            if (match && rtype == RX_ACK) begin
                                s.mode = MODE_FIN2;
                            end else begin
                                res[0] = resend_pending(s);
                                n = 1;
                            end
                        end
                        default: ;
                    endcase
                    s.sum = '0;
                    s.cnt = '0;
                    s.hdr = '0;
                end
            end
            KIND_TICK: begin
                if (s.mode == MODE_SYN || s.mode == MODE_PSH || s.mode == MODE_FIN) begin
                    if (s.timer < TIMER_MAX) begin
                        s.timer = s.timer + 16'd1;
                    end
                    if (s.timer >= s.tmo) begin
                        res[0] = resend_pending(s);
                        n = 1;
                    end
                end
            end
            default: ;
        endcase
        if (n > 0) begin
            res[n - 1].last = 1'b1;
        end
        return n;
    endfunction

    function automatic t_arq_item rand_item(logic [2:0] kind);
        t_arq_item c;
        c.kind  = kind;
        c.word  = 16'($urandom);
        c.lastw = 1'($urandom);
        c.flen  = 27'($urandom);
        c.hold  = ($urandom_range(99) == 0);
        return c;
    endfunction

    // The plan copy tracks the state the block will have once the queue drains.
    function automatic void enq(t_arq_item c);
        t_result scratch [2];
        pending_items.push_back(c);
        void'(arq_response(arq_plan, c, scratch));
        if (c.kind <= KIND_TICK) begin
            queued++;
        end
    endfunction

    function automatic void send_ticks(int n);
        for (int i = 0; i < n; i++) begin
            enq(rand_item(KIND_TICK));
        end
    endfunction

    // Word 0 makes the packet's ones' complement sum all ones; bad sums flip one bit.
    function automatic void send_reply(logic [7:0] rtype, logic [7:0] rseq, int nwords,
                                       bit good_sum);
        logic [15:0] w [8];
        int unsigned t;
        t_arq_item   c;
        for (int i = 0; i < 8; i++) begin
            w[i] = 16'($urandom);
        end
        if (nwords > HDR_INDEX) begin
            w[HDR_INDEX] = {rseq, rtype};
        end
        t = 0;
        for (int i = 1; i < nwords; i++) begin
            t = (t + w[i]) % 32'hffff;
        end
        w[0] = 16'hffff - 16'(t);
        if (!good_sum) begin
            w[0] = w[0] ^ (16'd1 << $urandom_range(15));
        end
        for (int i = 0; i < nwords; i++) begin
            c = rand_item(KIND_RXWORD);
            c.word  = w[i];
            c.lastw = (i == nwords - 1);
            enq(c);
            if (i < nwords - 1 && $urandom_range(99) < 3) begin
                send_ticks(1);
            end
        end
    endfunction

    function automatic void add_noise();
        t_arq_item c;
        case ($urandom_range(5))
            0: enq(rand_item(KIND_CONNECT));
            1: begin
                c = rand_item(KIND_SEND);
                if (arq_plan.mode == MODE_OPEN) begin
                    c.flen = $urandom_range(100);
                end
                enq(c);
            end
            2: enq(rand_item(KIND_DISC));
            3: send_ticks(1);
            4: enq(rand_item(3'($urandom_range(KIND_TICK + 1, 7))));
            default: send_reply(8'($urandom), 8'($urandom), $urandom_range(1, 4), 1'($urandom));
        endcase
    endfunction

    function automatic void run_traffic(int budget);
        int         stop_at;
        int         r;
        int         n;
        t_arq_item  c;
        logic [7:0] want_type;
        stop_at = queued + budget;
        while (queued < stop_at) begin
            r = $urandom_range(99);
            want_type = (arq_plan.mode == MODE_SYN) ? RX_SYNACK : RX_ACK;
            case (arq_plan.mode)
                MODE_CLOSED: begin
                    if (r < 75) begin
                        enq(rand_item(KIND_CONNECT));
                    end else begin
                        add_noise();
                    end
                end
                MODE_OPEN: begin
                    if (r < 50) begin
                        c = rand_item(KIND_SEND);
                        case ($urandom_range(2))
                            0: c.flen = $urandom_range(20000);
                            1: c.flen = SEG_MAX * $urandom_range(3);
                            default: c.flen = $urandom_range(1, 100);
                        endcase
                        enq(c);
                    end else if (r < 75) begin
                        enq(rand_item(KIND_DISC));
                    end else if (r < 87) begin
                        send_reply(8'($urandom), 8'($urandom), $urandom_range(1, 8),
                                   1'($urandom));
                    end else begin
                        add_noise();
                    end
                end
                MODE_FIN2: begin
                    if (r < 75) begin
                        send_reply(RX_FINACK, 8'($urandom), $urandom_range(5, 8), 1'($urandom));
                    end else begin
                        send_reply(8'($urandom), 8'($urandom), $urandom_range(1, 8),
                                   1'($urandom));
                    end
                end
                default: begin
                    if (r < 55) begin
                        send_reply(want_type, arq_plan.seq, $urandom_range(5, 8), 1'b1);
                    end else if (r < 70) begin
                        if (arq_plan.tmo <= 200 && $urandom_range(3) == 0) begin
                            n = (arq_plan.tmo == 0) ? 1 : int'(arq_plan.tmo);
                        end else begin
                            n = $urandom_range(1, 3);
                        end
                        send_ticks(n);
                    end else if (r < 90) begin
                        case ($urandom_range(3))
                            0: send_reply(want_type, arq_plan.seq + 8'($urandom_range(1, 255)),
                                          $urandom_range(5, 8), 1'b1);
                            1: send_reply(want_type ^ (8'd1 << $urandom_range(7)), arq_plan.seq,
                                          $urandom_range(5, 8), 1'b1);
                            2: send_reply(want_type, arq_plan.seq, $urandom_range(5, 8), 1'b0);
                            default: send_reply(want_type, arq_plan.seq, $urandom_range(1, 4),
                                                1'b1);
                        endcase
                    end else begin
                        add_noise();
                    end
                end
            endcase
        end
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || due_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        arq_model.tmo = v;
        arq_plan.tmo  = v;
    endtask

    // input channel: one transfer per accepted item, prediction at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                step_n = arq_response(arq_model, in_flight, step_res);
                for (int k = 0; k < step_n; k++) begin
                    due_results.push_back(step_res[k]);
                end
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() != 0
                        && !(pending_items[0].hold && due_results.size() != 0)
                        && (steady || $urandom_range(99) >= 37)) begin
                    in_flight = pending_items.pop_front();
                    i_valid       <= 1'b1;
                    i_kind        <= in_flight.kind;
                    i_rx_word     <= in_flight.word;
                    i_last_word   <= in_flight.lastw;
                    i_file_length <= in_flight.flen;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got.action   = o_action;
                got.pkt_type = o_pkt_type;
                got.pkt_seq  = o_pkt_seq;
                got.seg_len  = o_seg_len;
                got.status   = o_status;
                got.last     = o_last;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("action", want.action, got.action);
                    check_field("pkt_type", want.pkt_type, got.pkt_type);
                    check_field("pkt_seq", want.pkt_seq, got.pkt_seq);
                    check_field("seg_len", want.seg_len, got.seg_len);
                    check_field("status", want.status, got.status);
                    check_field("last", want.last, got.last);
                end
            end
            i_ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    initial begin
        t_arq_item   c;
        logic [15:0] tmo_list [6];
        tmo_list = '{16'd1, 16'd0, 16'd65535, 16'd5, 16'd100, 16'd23};
        arq_model.mode  = MODE_CLOSED;
        arq_model.seq   = '0;
        arq_model.timer = '0;
        arq_model.sum   = '0;
        arq_model.cnt   = '0;
        arq_model.hdr   = '0;
        arq_model.left  = '0;
        arq_model.pend  = '0;
        arq_model.tmo   = TIMEOUT_RESET;
        arq_plan = arq_model;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reserved kind with every field at its top value
        c = rand_item('1);
        c.word  = '1;
        c.lastw = 1'b1;
        c.flen  = '1;
        enq(c);
        c = rand_item(KIND_SEND);
        c.flen = '1;
        enq(c);
        enq(rand_item(KIND_DISC));
        send_ticks(1);
        send_reply(RX_ACK, arq_plan.seq, 5, 1'b1);
        enq(rand_item(KIND_CONNECT));
        enq(rand_item(KIND_CONNECT));
        send_reply(RX_SYNACK, arq_plan.seq, 1, 1'b1);
        send_reply(RX_SYNACK, arq_plan.seq, 5, 1'b1);
        c = rand_item(KIND_SEND);
        c.flen = '0;
        enq(c);
        send_reply(RX_ACK, arq_plan.seq, 5, 1'b1);
        c = rand_item(KIND_DISC);
        c.hold = 1'b1;
        enq(c);
        send_reply(RX_ACK, arq_plan.seq, 5, 1'b0);
        send_reply(RX_ACK, arq_plan.seq, 5, 1'b1);
        send_reply(RX_FINACK, 8'hff, 5, 1'b1);
        wait_drained();

        foreach (tmo_list[p]) begin
            write_timeout(tmo_list[p]);
            steady = (p == 2);
            run_traffic(230);
            wait_drained();
        end
        steady = 1'b0;
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0 && pending_items.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
